>>> src/lpd_pkg.sv
// shared types and constants for the length prefix deframer
package lpd_pkg;

  localparam int unsigned HEADER_BYTES    = 4;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned LEN_W           = HEADER_BYTES * BYTE_W;
  localparam int unsigned HCNT_W          = $clog2(HEADER_BYTES);
  localparam int unsigned MAX_PAYLOAD_W   = 21;
  localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RESET = MAX_PAYLOAD_W'(1020);

  localparam int unsigned APB_ADDR_W      = 3;
  localparam int unsigned APB_DATA_W      = 32;
  localparam logic [0:0]  REG_MAX_PAYLOAD = 1'b0;

  // one result item as produced by the deframing logic
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] payload_byte;
    logic              last;
    logic              empty_res;
  } lpd_res_t;

endpackage

>>> src/lpd_core.sv
// framing state and per-byte deframing logic
module lpd_core import lpd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     fire,
  input  logic [BYTE_W-1:0]        rx_byte,
  input  logic [MAX_PAYLOAD_W-1:0] max_payload,
  output lpd_res_t                 res
);

  logic [LEN_W-1:0]  header_shift, header_shift_next;
  logic [HCNT_W-1:0] header_count, header_count_next;
  logic [LEN_W-1:0]  bytes_left, bytes_left_next;
  logic              dropping, dropping_next;
  logic              in_payload, in_payload_next;

  logic              left_zero;
  logic              left_one;
  logic [LEN_W-1:0]  len;

  assign left_zero = (bytes_left == '0);
  assign left_one  = (bytes_left == LEN_W'(1));
  assign len       = {header_shift[LEN_W-BYTE_W-1:0], rx_byte};

  always_comb begin
    header_shift_next = header_shift;
    header_count_next = header_count;
    bytes_left_next   = bytes_left;
    dropping_next     = 1'b0;
    in_payload_next   = 1'b0;
    res               = '0;
    if (dropping && !left_zero) begin
      bytes_left_next = bytes_left - LEN_W'(1);
      dropping_next   = !left_one;
    end else if (in_payload && !left_zero) begin
      bytes_left_next  = bytes_left - LEN_W'(1);
      in_payload_next  = !left_one;
      res.valid        = 1'b1;
      res.payload_byte = rx_byte;
      res.last         = left_one;
    end else if (header_count == HCNT_W'(HEADER_BYTES - 1)) begin
      // header complete
      header_shift_next = '0;
      header_count_next = '0;
      if (len == '0) begin
        res.valid     = 1'b1;
        res.last      = 1'b1;
        res.empty_res = 1'b1;
      end else begin
        bytes_left_next = len;
        if (len > LEN_W'(max_payload)) begin
          dropping_next = 1'b1;
        end else begin
          in_payload_next = 1'b1;
        end
      end
    end else begin
      header_shift_next = len;
      header_count_next = header_count + HCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_shift <= '0;
      header_count <= '0;
      bytes_left   <= '0;
      dropping     <= 1'b0;
      in_payload   <= 1'b0;
    end else if (fire) begin
      header_shift <= header_shift_next;
      header_count <= header_count_next;
      bytes_left   <= bytes_left_next;
      dropping     <= dropping_next;
      in_payload   <= in_payload_next;
    end
  end

`ifndef SYNTHESIS
  a_modes_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(dropping && in_payload))
    else $error("drop and payload modes both set");

  a_header_only_framing: assert property (@(posedge clk) disable iff (rst)
    (header_count != '0) |-> (!dropping && !in_payload))
    else $error("header bytes gathered outside framing mode");
`endif

endmodule

>>> src/length_prefix_deframer.sv
// length prefix deframer top level: stream ports, input and result registers, config
// a held byte moves on to the result register and m_* once that register is free
// throughput: one byte per cycle unless m_tready stalls; the counter decrement and
//   length compare sit between the input register and the result register
// reset: synchronous, active high; clears framing state, both valid flags and sets
//   max_payload to 1020
module length_prefix_deframer import lpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] rx_byte
  // output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [BYTE_W-1:0]     m_tdata,   // [7:0] payload_byte
  output logic                  m_tlast,
  output logic                  m_tuser,   // [0] empty_res
  // config port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [MAX_PAYLOAD_W-1:0] max_payload;
  logic                     in_vld;
  logic [BYTE_W-1:0]        in_byte;
  logic                     fire;
  lpd_res_t                 res;

  // config register, index taken from the word address
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_PAYLOAD) ? APB_DATA_W'(max_payload) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_PAYLOAD)) begin
      max_payload <= pwdata[MAX_PAYLOAD_W-1:0];
    end
  end

  // the held byte moves on whenever the result register is free or being drained
  assign fire     = in_vld && (!m_tvalid || m_tready);
  assign s_tready = !in_vld || fire;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  lpd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .rx_byte     (in_byte),
    .max_payload (max_payload),
    .res         (res)
  );

  // result register; header and dropped bytes leave it untouched
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= res.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      m_tdata <= res.payload_byte;
      m_tlast <= res.last;
      m_tuser <= res.empty_res;
    end
  end

`ifndef SYNTHESIS
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("empty item without last");

  a_empty_no_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("empty item carries data");

  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> s_tready)
    else $error("input not ready after reset");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("pending result item overwritten");
`endif

endmodule

>>> tb/lpd_checker.sv
// watches both streams and the config port, predicts each result item and compares
`timescale 1ns / 1ps

module lpd_checker import lpd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] rx_byte
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [BYTE_W-1:0]     m_tdata,   // [7:0] payload_byte
  input  logic                  m_tlast,
  input  logic                  m_tuser,   // [0] empty_res
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int unsigned           fail_count,
  output int unsigned           pending
);

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              empty;
  } frame_out_t;

  frame_out_t want_q[$];

  logic [MAX_PAYLOAD_W-1:0] max_len;
  logic [LEN_W-1:0]         hdr_acc;
  logic [2:0]               hdr_cnt;
  logic [LEN_W-1:0]         remain;
  logic                     skipping;
  logic                     passing;

  // advance the framing state by one byte, queue the result item it gives
  task automatic deframe_byte(input logic [BYTE_W-1:0] b);
    frame_out_t       r;
    logic [LEN_W-1:0] len;
    if (skipping && remain == '0) skipping = 1'b0;
    if (passing && remain == '0) passing = 1'b0;
    if (skipping) begin
      remain = remain - 1'b1;
      if (remain == '0) skipping = 1'b0;
    end else if (passing) begin
      remain  = remain - 1'b1;
      r.data  = b;
      r.last  = (remain == '0);
      r.empty = 1'b0;
      if (r.last) passing = 1'b0;
      want_q.push_back(r);
    end else begin
      hdr_acc = {hdr_acc[LEN_W-BYTE_W-1:0], b};
      hdr_cnt = hdr_cnt + 3'd1;
      if (hdr_cnt >= 3'(HEADER_BYTES)) begin
        len     = hdr_acc;
        hdr_acc = '0;
        hdr_cnt = '0;
        if (len == '0) begin
          r.data  = '0;
          r.last  = 1'b1;
          r.empty = 1'b1;
          want_q.push_back(r);
        end else begin
          remain = len;
          if (len > LEN_W'(max_len)) skipping = 1'b1;
          else passing = 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk) begin : watch
    frame_out_t got;
    if (rst) begin
      max_len    = MAX_PAYLOAD_RESET;
      hdr_acc    = '0;
      hdr_cnt    = '0;
      remain     = '0;
      skipping   = 1'b0;
      passing    = 1'b0;
      fail_count = 0;
      want_q.delete();
    end else begin
      // outputs first, so an item taken in at this edge cannot match here
      if (m_tvalid && m_tready) begin
        if (want_q.size() == 0) begin
          $error("result item with nothing expected: payload_byte %0h last %0b empty_res %0b",
                 m_tdata, m_tlast, m_tuser);
          fail_count++;
        end else begin
          got = want_q.pop_front();
          if (m_tdata !== got.data) begin
            $error("payload_byte: expected %0h, got %0h", got.data, m_tdata);
            fail_count++;
          end
          if (m_tlast !== got.last) begin
            $error("last: expected %0b, got %0b", got.last, m_tlast);
            fail_count++;
          end
          if (m_tuser !== got.empty) begin
            $error("empty_res: expected %0b, got %0b", got.empty, m_tuser);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) deframe_byte(s_tdata);
      if (psel && penable && pready && paddr[APB_ADDR_W-1:2] == REG_MAX_PAYLOAD) begin
        if (pwrite) begin
          max_len = pwdata[MAX_PAYLOAD_W-1:0];
        end else if (prdata !== APB_DATA_W'(max_len)) begin
          $error("max_payload: expected %0h, got %0h", APB_DATA_W'(max_len), prdata);
          fail_count++;
        end
      end
    end
    pending = want_q.size();
  end

endmodule

>>> tb/tb.sv
// top of the deframer testbench: clock, reset, stimulus, stalls and the verdict
`timescale 1ns / 1ps

module tb;
  import lpd_pkg::*;

  localparam int unsigned HALF_NS       = 6;
  localparam int unsigned RESET_CYCLES  = 9;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  // long receiver hold-off, well past what the two internal registers can absorb
  localparam int unsigned HOLD_CYCLES   = 64;
  // a dropped byte may still sit in the input register
  localparam int unsigned SETTLE_CYCLES = 4;
  // register index with nothing behind it, writes there must be ignored
  localparam logic [0:0]  REG_SPARE     = 1'b1;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata  = '0;   // [7:0] rx_byte
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [BYTE_W-1:0]     m_tdata;         // [7:0] payload_byte
  logic                  m_tlast;
  logic                  m_tuser;         // [0] empty_res
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned fails;
  int unsigned pending;
  int unsigned sent    = 0;
  int unsigned gap_pct = 0;   // chance in percent of a sender gap after each item
  bit          calm      = 1'b0;   // no idling on either side
  bit          want_hold = 1'b0;   // asks the receiver for one long hold-off

  always begin
    #HALF_NS clk = 1'b1;
    #HALF_NS clk = 1'b0;
  end

  length_prefix_deframer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  lpd_checker chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fail_count (fails),
    .pending    (pending)
  );

  // offer one byte and hold it until taken; returns on a falling edge
  // with tvalid still high unless a gap follows
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    sent++;
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  // length header, most significant byte first
  task automatic send_header(input logic [LEN_W-1:0] len);
    for (int i = HEADER_BYTES - 1; i >= 0; i--) send_byte(len[i*BYTE_W +: BYTE_W]);
  endtask

  // whole message with random payload content
  task automatic send_message(input int unsigned len);
    send_header(LEN_W'(len));
    repeat (len) send_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  // stop offering, wait for every expected item, then let a dropped tail run out
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // setup, access, then idle so the next transfer starts clean
  task automatic apb_write(input logic [0:0] idx, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // read back; the checker compares prdata with its own copy
  task automatic apb_read(input logic [0:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // one max_payload setting and a stream of random messages under it
  task automatic run_phase(input logic [APB_DATA_W-1:0] wr, input int unsigned budget,
                           input int unsigned gap);
    logic [MAX_PAYLOAD_W-1:0] lim;
    int unsigned              stop;
    int unsigned              len;
    int unsigned              pick;
    drain();
    apb_write(REG_MAX_PAYLOAD, wr);
    apb_read(REG_MAX_PAYLOAD);
    lim     = wr[MAX_PAYLOAD_W-1:0];
    gap_pct = gap;
    stop    = sent + budget;
    while (sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // empty message
        len = 0;
      end else if (pick < 70) begin
        // short message, dropped when the limit is tiny
        len = $urandom_range(1, 12);
      end else if (pick < 85) begin
        // just under, at and just over a small limit; a medium length for a large one
        if (lim == 0) len = $urandom_range(0, 2);
        else if (lim < 32) len = int'(lim) - 1 + $urandom_range(0, 2);
        else len = $urandom_range(13, 64);
      end else begin
        // arbitrary low header byte
        len = $urandom_range(0, 255);
      end
      if (sent + HEADER_BYTES + len > stop) begin
        // trim the closing message so the phase keeps to its byte budget
        len = (stop > sent + HEADER_BYTES) ? stop - sent - HEADER_BYTES : 0;
      end
      send_message(len);
    end
  endtask

  // receiver: random stall bursts, stretches of steady ready, one long hold-off on request
  initial begin : receiver
    @(negedge clk);
    forever begin
      if (want_hold) begin
        want_hold = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!calm && $urandom_range(1, 100) <= 12) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end
    end
  end

  // runaway guard
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset value of the limit
    apb_read(REG_MAX_PAYLOAD);

    // directed: empty message, single extreme byte, two bytes starting at the low extreme
    send_header(0);
    send_header(1);
    send_byte(8'hFF);
    send_header(2);
    send_byte(8'h00);
    send_byte(8'hA5);

    // limit zero: a non-empty message is dropped, an empty one still reports
    drain();
    apb_write(REG_MAX_PAYLOAD, '0);
    send_header(2);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_header(0);

    // write to an index with no register behind it must leave the limit alone
    drain();
    apb_write(REG_SPARE, 32'h0000_0003);
    apb_read(REG_MAX_PAYLOAD);

    // largest value the register holds, above the nominal range
    run_phase(32'h001F_FFFF, 90, 15);
    // everything non-empty dropped
    run_phase(32'h0000_0000, 80, 25);
    run_phase(32'h0000_0001, 80, 5);
    // upper bits beyond the register width are cut off, leaving six
    run_phase(32'hFFE0_0006, 90, 20);
    // top of the nominal range, with one long hold-off while bytes keep coming
    want_hold = 1'b1;
    run_phase(32'h0010_0000, 90, 0);
    run_phase(32'h0000_0010, 80, 40);
    // closing stretch back at the reset value, no idling on either side
    calm = 1'b1;
    run_phase(32'd1020, 80, 0);

    drain();
    if (fails == 0 && pending == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
